// ===== sv/assert_macros.svh =====
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/ednms_pkg.sv =====
package ednms_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int ADDR_W     = $clog2(MAX_WIDTH);
	localparam int MAG_W      = 16;
	localparam int ANG_W      = 12;
	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 12;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W  = 1;
	localparam int WIDTH_CAP  = (MAX_WIDTH > (2 ** WIDTH_W) - 1) ? (2 ** WIDTH_W) - 1 : MAX_WIDTH;
	localparam int CNT_W      = ((ADDR_W > WIDTH_W) ? ADDR_W : WIDTH_W) + 1;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	typedef struct packed {
		logic                    mode;
		logic [MAG_W-1:0]        magnitude;
		logic signed [ANG_W-1:0] angle;
	} pixel_beat_t;

	typedef struct packed {
		logic [MAG_W-1:0] kept_magnitude;
		logic             frame_last;
	} result_beat_t;

	typedef struct packed {
		logic [MAG_W-1:0] up;
		logic [MAG_W-1:0] mid;
		logic [ANG_W-1:0] angle;
	} line_entry_t;

	typedef struct packed {
		logic              shift;
		logic              write;
		logic              emit;
		logic              top;
		logic              bottom;
		logic              left;
		logic              right;
		logic              last;
		logic [ADDR_W-1:0] addr;
	} slot_op_t;

	typedef struct packed {
		logic busy;
		logic exec;
		logic emit;
	} slot_status_t;

endpackage

// ===== sv/edge_non_max_suppression.sv =====
// Order: a pixel is decided by the beat frame_width+1 places later. That beat loads the slot
//   stage on the accepting edge; its result enters the output register when the slot stage
//   retires it, and the beat is held there while the output register is full and stalled.
// Throughput: one beat per cycle unless held, set by the single read-modify-write store port.
// Reset: positions, pending count and handshake state clear, frame size returns to 640 x 480;
//   the line store is not cleared, and there is no clearing pass after reset.
`include "assert_macros.svh"

module edge_non_max_suppression (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 pixel_valid,
	output logic                                 pixel_stall,
	input  ednms_pkg::pixel_beat_t               pixel,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output ednms_pkg::result_beat_t              result,
	input  logic                                 write_en,
	input  logic [ednms_pkg::CFG_IDX_W-1:0]      write_index,
	input  logic [ednms_pkg::CFG_DATA_W-1:0]     write_data
);
	import ednms_pkg::*;

	// The sequencer tracks the raster positions of the input and of the pixel under decision,
	// the number of pixels still pending and the progress of a frame-end drain. It turns each
	// accepted beat into a slot operation: shift the window, write the line store, emit.
	// Flush beats that arrive away from a frame boundary are taken and dropped there.
	slot_op_t     op;
	slot_status_t status;
	line_entry_t  entry;
	logic         pixel_accept, load;

	assign pixel_accept = pixel_valid && !pixel_stall;
	assign load         = pixel_accept && op.shift;

	// A beat is held back only while the slot stage holds an item that cannot retire,
	// which happens when it must emit and the output register is full and stalled.
	assign pixel_stall = status.busy && !status.exec;

	ednms_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (pixel_accept),
		.pixel       (pixel),
		.write_en    (write_en),
		.write_index (write_index),
		.write_data  (write_data),
		.op          (op)
	);

	// The line store keeps, for every column, the two previous rows of magnitude and the
	// previous row's angle in one word. It is read when a beat is accepted and written back
	// when that beat leaves the slot stage, with a bypass for back-to-back beats on one column
	// (a frame one pixel wide).
	ednms_line_store u_line_store (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.op     (op),
		.pixel  (pixel),
		.exec   (status.exec),
		.entry  (entry)
	);

	// The window keeps two columns of the 3x3 neighborhood in registers; the third comes from
	// the line store word and the incoming magnitude. It classifies the centre angle into one
	// of four directions and compares against the two in-frame neighbors along it.
	ednms_window u_window (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.op           (op),
		.pixel        (pixel),
		.entry        (entry),
		.result_stall (result_stall),
		.status       (status),
		.result_valid (result_valid),
		.result       (result)
	);

	// Only pixel beats may write the line store.
	`ASSERT_IMPLIES(a_flush_no_write, clk, arst_n, load && op.write, pixel.mode == MODE_PIXEL, "flush beat scheduled a line store write")
	// A new result beat comes only from an emitting item that retired from the slot.
	`ASSERT_IMPLIES(a_result_from_slot, clk, arst_n, $rose(result_valid), $past(status.exec && status.emit), "result appeared without an emitting slot item")
	// An item that emits nothing never waits in the slot stage.
	`ASSERT_IMPLIES(a_silent_retires, clk, arst_n, status.busy && !status.emit, status.exec, "non-emitting slot item held back")

endmodule

// ===== sv/ednms_seq.sv =====
module ednms_seq (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 accept,
	input  ednms_pkg::pixel_beat_t               pixel,
	input  logic                                 write_en,
	input  logic [ednms_pkg::CFG_IDX_W-1:0]      write_index,
	input  logic [ednms_pkg::CFG_DATA_W-1:0]     write_data,
	output ednms_pkg::slot_op_t                  op
);
	import ednms_pkg::*;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);

	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [ADDR_W-1:0]   in_col_q, out_col_q;
	logic [HEIGHT_W-1:0] in_row_q, out_row_q;
	logic [CNT_W-1:0]    pending_q, drain_q;

	logic [CNT_W-1:0]    w_c, w_plus1, in_col_inc, out_col_inc, pend_base, drain_col;
	logic [CNT_W-1:0]    drain_inc, pending_dec;
	logic [CNT_W:0]      drain_sum;
	logic                in_col_wrap, in_row_wrap, out_col_wrap, out_row_wrap;
	logic                is_pixel, flush_ok;
	logic [WIDTH_W-1:0]  width_in;
	logic [HEIGHT_W-1:0] height_in;

	assign w_c         = CNT_W'(width_q);
	assign w_plus1     = w_c + CNT_W'(1);
	assign in_col_inc  = CNT_W'(in_col_q) + CNT_W'(1);
	assign out_col_inc = CNT_W'(out_col_q) + CNT_W'(1);
	assign in_col_wrap  = in_col_inc >= w_c;
	assign out_col_wrap = out_col_inc >= w_c;
	assign in_row_wrap  = (in_row_q + HEIGHT_W'(1)) >= height_q;
	assign out_row_wrap = (out_row_q + HEIGHT_W'(1)) >= height_q;
	assign is_pixel    = pixel.mode == MODE_PIXEL;
	assign flush_ok    = (pending_q != '0) && (in_col_q == '0) && (in_row_q == '0);
	assign pend_base   = (drain_q != '0) ? '0 : pending_q;
	assign drain_col   = (drain_q >= w_c) ? drain_q - w_c : drain_q;
	assign drain_inc   = drain_q + CNT_W'(1);
	assign pending_dec = pending_q - CNT_W'(1);
	assign drain_sum   = {1'b0, pending_q} + {1'b0, drain_q};

	// Zero and oversize register values are clamped when written.
	always_comb begin
		width_in = write_data[WIDTH_W-1:0];
		if (width_in == '0) begin
			width_in = WIDTH_W'(1);
		end else if (32'(width_in) > WIDTH_CAP) begin
			width_in = WIDTH_W'(WIDTH_CAP);
		end
		height_in = write_data[HEIGHT_W-1:0];
		if (height_in == '0) begin
			height_in = HEIGHT_W'(1);
		end
	end

	always_comb begin
		op        = '0;
		op.top    = out_row_q == '0;
		op.bottom = out_row_q == height_q - HEIGHT_W'(1);
		op.left   = out_col_q == '0;
		op.right  = CNT_W'(out_col_q) == w_c - CNT_W'(1);
		op.last   = op.bottom && op.right;
		if (is_pixel) begin
			op.shift = 1'b1;
			op.write = 1'b1;
			op.addr  = in_col_q;
			op.emit  = pend_base == w_plus1;
		end else if (flush_ok) begin
			op.shift = 1'b1;
			op.addr  = drain_col[ADDR_W-1:0];
			op.emit  = drain_sum >= {1'b0, w_plus1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= WIDTH_RESET;
			height_q  <= HEIGHT_RESET;
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pending_q <= '0;
			drain_q   <= '0;
		end else if (write_en) begin
			unique case (write_index)
				REG_FRAME_WIDTH:  width_q  <= width_in;
				REG_FRAME_HEIGHT: height_q <= height_in;
			endcase
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pending_q <= '0;
			drain_q   <= '0;
		end else if (accept) begin
			if (is_pixel) begin
				in_col_q <= in_col_wrap ? '0 : in_col_inc[ADDR_W-1:0];
				if (in_col_wrap) begin
					in_row_q <= in_row_wrap ? '0 : in_row_q + HEIGHT_W'(1);
				end
				pending_q <= op.emit ? pend_base : pend_base + CNT_W'(1);
				drain_q   <= '0;
			end else if (flush_ok) begin
				if (op.emit) begin
					pending_q <= pending_dec;
					drain_q   <= (pending_dec == '0) ? '0 : drain_inc;
				end else begin
					drain_q <= drain_inc;
				end
			end
			if (op.emit) begin
				out_col_q <= out_col_wrap ? '0 : out_col_inc[ADDR_W-1:0];
				if (out_col_wrap) begin
					out_row_q <= out_row_wrap ? '0 : out_row_q + HEIGHT_W'(1);
				end
			end
		end
	end

endmodule

// ===== sv/ednms_line_store.sv =====
module ednms_line_store (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  ednms_pkg::slot_op_t    op,
	input  ednms_pkg::pixel_beat_t pixel,
	input  logic                   exec,
	output ednms_pkg::line_entry_t entry
);
	import ednms_pkg::*;

	line_entry_t       mem_q [MAX_WIDTH];
	line_entry_t       rd_s1, fwd_data_s1, wdata;
	logic              fwd_s1, write_s1, hit;
	logic [ADDR_W-1:0] addr_s1;
	logic [MAG_W-1:0]  mag_s1;
	logic [ANG_W-1:0]  ang_s1;

	// The slot item's write lands on the same edge as the next read, so a
	// read of the same column takes the write data instead of the stale word.
	assign entry = fwd_s1 ? fwd_data_s1 : rd_s1;
	assign wdata = '{up: entry.mid, mid: mag_s1, angle: ang_s1};
	assign hit   = exec && write_s1 && (op.addr == addr_s1);

	always_ff @(posedge clk) begin
		if (exec && write_s1) begin
			mem_q[addr_s1] <= wdata;
		end
		if (load) begin
			rd_s1       <= mem_q[op.addr];
			fwd_data_s1 <= wdata;
			addr_s1     <= op.addr;
			mag_s1      <= pixel.magnitude;
			ang_s1      <= $unsigned(pixel.angle);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (load) begin
			write_s1 <= op.write;
			fwd_s1   <= hit;
		end
	end

endmodule

// ===== sv/ednms_window.sv =====
module ednms_window (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  ednms_pkg::slot_op_t     op,
	input  ednms_pkg::pixel_beat_t  pixel,
	input  ednms_pkg::line_entry_t  entry,
	input  logic                    result_stall,
	output ednms_pkg::slot_status_t status,
	output logic                    result_valid,
	output ednms_pkg::result_beat_t result
);
	import ednms_pkg::*;

	localparam logic signed [ANG_W-1:0] ANG_22_5 = 12'sd360;
	localparam logic signed [ANG_W-1:0] ANG_67_5 = 12'sd1080;
	localparam logic signed [ANG_W-1:0] ANG_91   = 12'sd1456;

	localparam logic [1:0] DIR_HORZ    = 2'd0;
	localparam logic [1:0] DIR_RISING  = 2'd1;
	localparam logic [1:0] DIR_VERT    = 2'd2;
	localparam logic [1:0] DIR_FALLING = 2'd3;

	typedef struct packed {
		logic [MAG_W-1:0] up;
		logic [MAG_W-1:0] mid;
		logic [MAG_W-1:0] down;
	} col_t;

	logic                    valid_s1, result_valid_q, exec, suppress;
	slot_op_t                op_s1;
	logic [MAG_W-1:0]        down_s1, centre, n1, n2;
	logic                    v1, v2;
	col_t                    col_a_q, col_b_q, new_col;
	logic signed [ANG_W-1:0] ang_b_q;
	logic [1:0]              dir;
	result_beat_t            result_q;

	assign new_col = '{up: entry.up, mid: entry.mid, down: down_s1};
	assign exec    = valid_s1 && (!op_s1.emit || !result_valid_q || !result_stall);
	assign centre  = col_b_q.mid;

	always_comb begin
		priority if (ang_b_q > -ANG_22_5 && ang_b_q <= ANG_22_5) begin
			dir = DIR_HORZ;
		end else if (ang_b_q > ANG_22_5 && ang_b_q <= ANG_67_5) begin
			dir = DIR_RISING;
		end else if ((ang_b_q > ANG_67_5 && ang_b_q <= ANG_91) ||
				(ang_b_q > -ANG_91 && ang_b_q <= -ANG_67_5)) begin
			dir = DIR_VERT;
		end else begin
			dir = DIR_FALLING;
		end
	end

	// Neighbors outside the frame never suppress the centre pixel.
	always_comb begin
		unique case (dir)
			DIR_HORZ: begin
				n1 = new_col.mid;  v1 = !op_s1.right;
				n2 = col_a_q.mid;  v2 = !op_s1.left;
			end
			DIR_RISING: begin
				n1 = new_col.up;   v1 = !op_s1.top && !op_s1.right;
				n2 = col_a_q.down; v2 = !op_s1.bottom && !op_s1.left;
			end
			DIR_VERT: begin
				n1 = col_b_q.down; v1 = !op_s1.bottom;
				n2 = col_b_q.up;   v2 = !op_s1.top;
			end
			default: begin
				n1 = col_a_q.up;   v1 = !op_s1.top && !op_s1.left;
				n2 = new_col.down; v2 = !op_s1.bottom && !op_s1.right;
			end
		endcase
		suppress = (v1 && centre < n1) || (v2 && centre < n2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_s1 <= 1'b1;
			end else if (exec) begin
				valid_s1 <= 1'b0;
			end
			if (exec && op_s1.emit) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			op_s1   <= op;
			down_s1 <= (pixel.mode == MODE_PIXEL) ? pixel.magnitude : '0;
		end
		if (exec) begin
			col_a_q <= col_b_q;
			col_b_q <= new_col;
			ang_b_q <= $signed(entry.angle);
			if (op_s1.emit) begin
				result_q.kept_magnitude <= suppress ? '0 : centre;
				result_q.frame_last     <= op_s1.last;
			end
		end
	end

	assign status.busy  = valid_s1;
	assign status.exec  = exec;
	assign status.emit  = op_s1.emit;
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== tb/sv/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ednms_pkg::*;

	// Direction boundaries of the angle field, in 1/16 degree.
	localparam int ANG_22_5 = 360;
	localparam int ANG_67_5 = 1080;
	localparam int ANG_91   = 1456;

	localparam int RANDOM_ITEMS  = 620;
	// Quiet cycles allowed after the last expected beat before the block counts as idle.
	// The decision pipe is the slot stage and the output register, so this leaves a comfortable margin.
	localparam int SETTLE_CYCLES = 8;
	// Cycles without any accepted beat on either side before the run is declared hung.
	localparam int STALL_LIMIT   = 1000;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  pixel_valid  = 1'b0;
	logic                  pixel_stall;
	pixel_beat_t           pixel        = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	result_beat_t          result;
	logic                  write_en     = 1'b0;
	logic [CFG_IDX_W-1:0]  write_index  = '0;
	logic [CFG_DATA_W-1:0] write_data   = '0;

	edge_non_max_suppression DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.write_en     (write_en),
		.write_index  (write_index),
		.write_data   (write_data)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Suppression predictor. It mirrors the block's line stores and 3x3
	// window, so each accepted beat advances it exactly like the hardware.
	// ------------------------------------------------------------------
	bit [MAG_W-1:0]    line_mag [0:2*MAX_WIDTH-1];  // lower half: two rows up, upper half: one row up
	bit [ANG_W-1:0]    line_ang [0:MAX_WIDTH-1];
	bit [MAG_W-1:0]    win_mag  [0:2][0:2];         // indexed [column][row]
	bit [ANG_W-1:0]    ang_mid;
	bit [ANG_W-1:0]    ang_next;
	int unsigned       in_col, in_row, out_col, out_row;
	int unsigned       pending_px, drain_px;
	bit [WIDTH_W-1:0]  cfg_width;
	bit [HEIGHT_W-1:0] cfg_height;

	result_beat_t kept_expected [$];
	pixel_beat_t  beats_to_send [$];

	int  beats_outstanding = 0;
	int  random_items      = 0;
	int  mismatches        = 0;
	int  quiet_cycles      = 0;
	int  sender_idle_pct   = 0;
	int  receiver_idle_pct = 0;
	logic pixel_taken      = 1'b0;

	// A zero width behaves as one pixel, and anything past the row store is clamped.
	function automatic int unsigned used_width();
		if (cfg_width == 0) return 1;
		if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
		return 32'(cfg_width);
	endfunction

	function automatic int unsigned used_height();
		return (cfg_height == 0) ? 1 : 32'(cfg_height);
	endfunction

	task automatic restart_stream();
		in_col = 0;
		in_row = 0;
		out_col = 0;
		out_row = 0;
		pending_px = 0;
		drain_px = 0;
	endtask

	task automatic reset_predictor();
		foreach (line_mag[i]) line_mag[i] = '0;
		foreach (line_ang[i]) line_ang[i] = '0;
		foreach (win_mag[i, j]) win_mag[i][j] = '0;
		ang_mid = '0;
		ang_next = '0;
		cfg_width = WIDTH_W'(640);
		cfg_height = HEIGHT_W'(480);
		restart_stream();
	endtask

	// Slide the window one column right. The new right column is read from the
	// line stores at this column; a pixel beat also pushes its values into them.
	task automatic shift_window(int unsigned col, bit [MAG_W-1:0] down, bit store,
			bit [MAG_W-1:0] mag, bit [ANG_W-1:0] ang);
		int unsigned k;
		k = col % MAX_WIDTH;
		for (int c = 0; c < 3; c++) begin
			win_mag[0][c] = win_mag[1][c];
			win_mag[1][c] = win_mag[2][c];
		end
		win_mag[2][0] = line_mag[k];
		win_mag[2][1] = line_mag[MAX_WIDTH + k];
		win_mag[2][2] = down;
		ang_mid = ang_next;
		ang_next = line_ang[k];
		if (store) begin
			line_mag[k] = line_mag[MAX_WIDTH + k];
			line_mag[MAX_WIDTH + k] = mag;
			line_ang[k] = ang;
		end
	endtask

	// Decide the window centre: zero it when a neighbor along its gradient
	// direction lies inside the frame and is strictly larger.
	task automatic decide_pixel();
		int unsigned  w, h;
		int           a, r, c;
		int           dr [2];
		int           dc [2];
		bit [MAG_W-1:0] centre;
		result_beat_t beat;
		w = used_width();
		h = used_height();
		a = int'($signed(ang_mid));
		if (a > -ANG_22_5 && a <= ANG_22_5) begin
			dr = '{0, 0};
			dc = '{1, -1};
		end else if (a > ANG_22_5 && a <= ANG_67_5) begin
			dr = '{-1, 1};
			dc = '{1, -1};
		end else if ((a > ANG_67_5 && a <= ANG_91) || (a > -ANG_91 && a <= -ANG_67_5)) begin
			dr = '{1, -1};
			dc = '{0, 0};
		end else begin
			// Everything else, including angles beyond the nominal range, is the
			// up-left / down-right diagonal.
			dr = '{-1, 1};
			dc = '{-1, 1};
		end
		centre = win_mag[1][1];
		beat.kept_magnitude = centre;
		for (int n = 0; n < 2; n++) begin
			r = int'(out_row) + dr[n];
			c = int'(out_col) + dc[n];
			if (r >= 0 && r < int'(h) && c >= 0 && c < int'(w) &&
					centre < win_mag[dc[n] + 1][dr[n] + 1])
				beat.kept_magnitude = '0;
		end
		beat.frame_last = (out_row == h - 1 && out_col == w - 1);
		kept_expected.push_back(beat);
		out_col++;
		if (out_col >= w) begin
			out_col = 0;
			out_row++;
			if (out_row >= h) out_row = 0;
		end
		pending_px--;
	endtask

	task automatic predict_beat(pixel_beat_t b);
		int unsigned w, h, col;
		w = used_width();
		h = used_height();
		if (b.mode == MODE_PIXEL) begin
			// A pixel arriving in the middle of a drain drops what was left of it.
			if (drain_px != 0) begin
				pending_px = 0;
				drain_px = 0;
			end
			shift_window(in_col, b.magnitude, 1'b1, b.magnitude, b.angle);
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
				if (in_row >= h) in_row = 0;
			end
			pending_px++;
			if (pending_px >= w + 2) decide_pixel();
		end else if (pending_px != 0 && in_col == 0 && in_row == 0) begin
			// Flush only counts at a frame boundary with pixels still waiting.
			drain_px++;
			col = drain_px - 1;
			if (col >= w) col -= w;
			shift_window(col, '0, 1'b0, '0, '0);
			if (pending_px + drain_px >= w + 2) begin
				decide_pixel();
				if (pending_px == 0) drain_px = 0;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Checking.
	// ------------------------------------------------------------------
	task automatic flag_mismatch(string what);
		mismatches++;
		$display("%0t ns: %s", $realtime, what);
	endtask

	task automatic check_result(result_beat_t got);
		result_beat_t want;
		if (kept_expected.size() == 0) begin
			flag_mismatch($sformatf("unexpected result beat: kept_magnitude %h frame_last %b",
				got.kept_magnitude, got.frame_last));
		end else begin
			want = kept_expected.pop_front();
			if (got.kept_magnitude !== want.kept_magnitude)
				flag_mismatch($sformatf("kept_magnitude %h, expected %h",
					got.kept_magnitude, want.kept_magnitude));
			if (got.frame_last !== want.frame_last)
				flag_mismatch($sformatf("frame_last %b, expected %b (kept_magnitude %h)",
					got.frame_last, want.frame_last, want.kept_magnitude));
		end
	endtask

	// ------------------------------------------------------------------
	// Driver: inputs move on the falling edge only. A new beat is offered
	// when the previous one was taken at the last rising edge, or when the
	// channel is empty; otherwise the stalled beat is held untouched.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (!pixel_valid || pixel_taken) begin
				if (beats_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					pixel <= beats_to_send.pop_front();
					pixel_valid <= 1'b1;
				end else begin
					pixel_valid <= 1'b0;
				end
			end
			result_stall <= ($urandom_range(99) < receiver_idle_pct);
		end
	end

	// ------------------------------------------------------------------
	// Monitor: both handshakes are sampled on the rising edge. The result
	// side is checked before the new input beat is predicted, so a beat that
	// shows up with nothing queued can never be matched against its own
	// freshly predicted expectation.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			pixel_taken <= pixel_valid && !pixel_stall;
			if (result_valid && !result_stall) check_result(result);
			if (pixel_valid && !pixel_stall) begin
				predict_beat(pixel);
				beats_outstanding--;
			end
			if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Hang detection: a run that stops moving beats is a failure.
	initial begin
		wait (quiet_cycles >= STALL_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------

	// Writes happen only while the stream is idle. The predictor takes the new
	// value at the same edge as the block, and the stream restarts at a frame start.
	// The task returns on a rising edge so that the caller's queue updates never
	// race the falling-edge driver.
	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		write_en <= 1'b1;
		write_index <= idx;
		write_data <= value;
		@(posedge clk);
		if (idx == REG_FRAME_WIDTH)
			cfg_width = value[WIDTH_W-1:0];
		else
			cfg_height = value[HEIGHT_W-1:0];
		restart_stream();
		@(negedge clk);
		write_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_frame(logic [CFG_DATA_W-1:0] width_value,
			logic [CFG_DATA_W-1:0] height_value);
		write_register(REG_FRAME_WIDTH, width_value);
		write_register(REG_FRAME_HEIGHT, height_value);
	endtask

	// Wait until every queued beat has been accepted and every predicted result
	// has come back, then give the pipe time to finish any silent work. Both
	// counters only change on the rising edge, so they are read on the falling one.
	task automatic settle();
		while (beats_outstanding != 0 || kept_expected.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic queue_beat(pixel_beat_t b);
		beats_to_send.push_back(b);
		beats_outstanding++;
	endtask

	task automatic queue_pixel(bit [MAG_W-1:0] mag, int ang);
		pixel_beat_t b;
		b.mode = MODE_PIXEL;
		b.magnitude = mag;
		b.angle = ang[ANG_W-1:0];
		queue_beat(b);
	endtask

	// Flush beats carry random junk in the ignored fields.
	task automatic queue_flushes(int unsigned n);
		pixel_beat_t b;
		repeat (n) begin
			b.mode = MODE_FLUSH;
			b.magnitude = MAG_W'($urandom);
			b.angle = ANG_W'($urandom);
			queue_beat(b);
		end
	endtask

	// Small values and the extremes show up often so that ties and strict
	// comparisons against neighbors are both exercised.
	function automatic bit [MAG_W-1:0] pick_magnitude();
		case ($urandom_range(3))
			0: return MAG_W'($urandom_range(3));
			1: begin
				case ($urandom_range(3))
					0: return 16'h0000;
					1: return 16'hFFFF;
					2: return 16'h8000;
					default: return 16'h7FFF;
				endcase
			end
			default: return MAG_W'($urandom);
		endcase
	endfunction

	// Angles: anywhere in the nominal range, anywhere in the 12-bit field, or
	// right on and next to one of the direction boundaries.
	function automatic int pick_angle();
		int a;
		case ($urandom_range(5))
			0: a = $urandom_range(4095);
			1, 2: begin
				case ($urandom_range(6))
					0: a = ANG_22_5;
					1: a = -ANG_22_5;
					2: a = ANG_67_5;
					3: a = -ANG_67_5;
					4: a = ANG_91;
					5: a = -ANG_91;
					default: a = $urandom_range(1) ? 2047 : -2048;
				endcase
				if (a > -2048 && a < 2047) a = a + int'($urandom_range(2)) - 1;
			end
			default: a = int'($urandom_range(2 * ANG_91)) - ANG_91;
		endcase
		return a;
	endfunction

	task automatic queue_random_pixels(int unsigned n);
		repeat (n) queue_pixel(pick_magnitude(), pick_angle());
	endtask

	// One full frame in raster order. Now and then a stray flush lands inside
	// the frame, where the block must ignore it.
	task automatic queue_frame(int unsigned w, int unsigned h);
		for (int unsigned i = 0; i < w * h; i++) begin
			if (i != 0 && $urandom_range(19) == 0) queue_flushes(1);
			queue_pixel(pick_magnitude(), pick_angle());
		end
	endtask

	// The idling pattern moves on as the random part progresses: receiver
	// bursty first, then sender bursty, then both running flat out.
	task automatic pick_idling();
		if (random_items < RANDOM_ITEMS / 3) begin
			sender_idle_pct = 22;
			receiver_idle_pct = 57;
		end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
			sender_idle_pct = 57;
			receiver_idle_pct = 22;
		end else begin
			sender_idle_pct = 0;
			receiver_idle_pct = 0;
		end
	endtask

	// A random frame size followed by a few frames, each ended by a full drain,
	// a drain cut short by the next frame, a drain with surplus flushes, or nothing
	// at all (the next frame pushes the old one out); the tallest size gets part of one frame.
	task automatic random_session();
		int unsigned w_reg, h_reg, w, h, cut, frames;
		pick_idling();
		case ($urandom_range(9))
			0: w_reg = 0;
			1: w_reg = 1;
			2: w_reg = 2;
			3: w_reg = $urandom_range(13, 24);
			default: w_reg = $urandom_range(3, 12);
		endcase
		case ($urandom_range(9))
			0: h_reg = 0;
			1: h_reg = 1;
			// The tallest frame is only ever started, and only with narrow rows.
			2: h_reg = (w_reg <= 3) ? 4095 : 2;
			default: h_reg = $urandom_range(2, 6);
		endcase
		// Bit 11 of the data word lies above the width register and must be dropped.
		set_frame(CFG_DATA_W'(w_reg | ($urandom_range(1) << WIDTH_W)), CFG_DATA_W'(h_reg));
		w = (w_reg == 0) ? 1 : w_reg;
		h = (h_reg == 0) ? 1 : h_reg;
		if (h == 4095) begin
			cut = $urandom_range(20, 60);
			queue_random_pixels(cut);
			random_items += cut;
		end else begin
			frames = $urandom_range(1, 4);
			for (int unsigned f = 0; f < frames && random_items < RANDOM_ITEMS; f++) begin
				queue_frame(w, h);
				random_items += w * h;
				case ($urandom_range(9))
					0: ;
					1: begin
						cut = $urandom_range(1, w);
						queue_flushes(cut);
						random_items += cut;
					end
					2: begin
						queue_flushes(w + 1 + $urandom_range(1, 2));
						random_items += w + 1;
					end
					default: begin
						queue_flushes(w + 1);
						random_items += w + 1;
					end
				endcase
			end
		end
		settle();
	endtask

	// ------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------
	initial begin
		reset_predictor();
		sender_idle_pct = 22;
		receiver_idle_pct = 57;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed 3x3 frame. The centre sits on a horizontal gradient with an
		// equal left neighbor and a smaller right one, so it must survive the
		// strict comparison. The corners and edges use the field extremes and
		// boundary angles. A flush in mid-frame is ignored; the drain takes
		// width+1 flushes and the surplus one after it does nothing.
		set_frame(CFG_DATA_W'(3), CFG_DATA_W'(3));
		queue_pixel(16'h0000, -2048);
		queue_pixel(16'hFFFF, 2047);
		queue_pixel(16'h1234, -ANG_67_5);
		queue_flushes(1);
		queue_pixel(16'h8000, ANG_22_5 + 1);
		queue_pixel(16'h8000, 0);
		queue_pixel(16'h7FFF, ANG_67_5);
		queue_pixel(16'h0001, ANG_67_5 + 1);
		queue_pixel(16'hFFFE, ANG_91);
		queue_pixel(16'h4000, -ANG_91 - 1);
		queue_flushes(4);
		queue_flushes(1);
		settle();

		// Zero width and height both act as one: every pixel is its own frame.
		// A pixel that arrives after the first drain flush discards the rest of
		// that drain; the second drain runs to completion.
		set_frame(CFG_DATA_W'(0), CFG_DATA_W'(0));
		queue_random_pixels(3);
		queue_flushes(1);
		queue_random_pixels(2);
		queue_flushes(2);
		settle();

		while (random_items < RANDOM_ITEMS)
			random_session();

		settle();
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== edge_non_max_suppression.f =====
+incdir+sv
sv/ednms_pkg.sv
sv/ednms_seq.sv
sv/ednms_line_store.sv
sv/ednms_window.sv
sv/edge_non_max_suppression.sv
tb/sv/tb.sv
